// ===== rtl/core/nms_pkg.sv =====
// Shared types and constants for the non-adjacent maximum sum block.
// No dependencies; imported by nms_dp_unit and nonadjacent_max_sum_updates.
package nms_pkg;

  // Field widths of the item and result channels.
  localparam int unsigned CMD_W   = 1;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned VALUE_W = 18;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned QSUM_W  = 26;
  localparam int unsigned TOTAL_W = 30;

  // Internal sum width: holds the positive elements of the longest scan.
  localparam int unsigned SUM_W = 28;

  // Running total modulus.
  localparam logic [TOTAL_W:0] TOTAL_MOD = 31'd1000000007;

  // Item command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  // Configuration register map.
  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] ADDR_ARRAY_LENGTH = 2'd0;
  localparam logic [LEN_W-1:0]  ARRAY_LENGTH_RST  = 11'd1;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic step;
  } dp_ctl_t;

endpackage

// ===== rtl/core/nonadjacent_max_sum_updates.sv =====
// Top level of the non-adjacent maximum sum block: element memory, scan sequencer,
// running total and configuration port. Depends on nms_pkg and nms_dp_unit.
//
// Usage:
//   Items arrive on in_valid/in_stall with in_cmd, in_position and in_value.
//   A load item writes one element in the cycle it is accepted and yields no
//   result; the next item may follow in the next cycle.
//   A query item writes its element, then scans the first array_length
//   elements (capped at MAX_LEN) one memory read per cycle through a single
//   shared include/exclude unit. The result appears on out_valid after the
//   scan; in_stall is high for the whole scan and until the result enters the
//   output register, so a query occupies the block until then.
//   The element memory's single read port paces the scan.
//   The result sits in an output register until taken. While out_stall holds
//   it, load items and the scan of a new query proceed; a finished query
//   waits for the output register before it updates the running total.
//   array_length is written over the APB-style cfg_ port at byte address 0.
//   Reset (rst_n low, synchronous) clears the running total, sets
//   array_length to 1 and drops out_valid. Element memory is not cleared:
//   elements must be loaded before a query scans them.
module nonadjacent_max_sum_updates
  import nms_pkg::*;
#(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Item channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic [POS_W-1:0]          in_position,
  input  logic signed [VALUE_W-1:0] in_value,
  // Result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [QSUM_W-1:0]         out_query_max_sum,
  output logic [TOTAL_W-1:0]        out_running_total,
  // Configuration port
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [CFG_AW-1:0]         cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]               state_r;
  logic [1:0]               state_nxt;
  logic [LEN_W-1:0]         len_r;
  logic [LEN_W-1:0]         n_r;
  logic [LEN_W-1:0]         n_nxt;
  logic [LEN_W-1:0]         idx_r;
  logic                     rd_vld_r;
  logic                     issue;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic                     wr_ok;
  logic signed [VALUE_W-1:0] mem [MAX_LEN];
  logic signed [VALUE_W-1:0] mem_q_r;
  logic                     in_acc;
  logic                     query_acc;
  logic                     scan_done;
  logic                     out_free;
  logic [QSUM_W-1:0]        best;
  logic [QSUM_W-1:0]        sum_r;
  logic [TOTAL_W-1:0]       total_r;
  logic [TOTAL_W:0]         tot_sum;
  logic [TOTAL_W-1:0]       tot_nxt;
  logic                     out_valid_r;
  logic [QSUM_W-1:0]        out_sum_r;
  logic [TOTAL_W-1:0]       out_total_r;
  logic                     cfg_wr;
  dp_ctl_t                  dp_ctl;

  // Handshakes.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign query_acc = in_acc && (in_cmd == CMD_QUERY);
  assign out_free  = !out_valid_r || !out_stall;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= ARRAY_LENGTH_RST;
    end else if (cfg_wr && (cfg_paddr == ADDR_ARRAY_LENGTH)) begin
      len_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_ARRAY_LENGTH) begin
      cfg_prdata = 32'(len_r);
    end
  end

  // Scanned length is capped at the store depth.
  assign n_nxt = (32'(len_r) > 32'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_r;

  // Element memory: one write on item acceptance, one read per scan cycle.
  assign wr_ok   = (32'(in_position) < 32'(MAX_LEN));
  assign wr_addr = AW'(in_position);
  assign issue   = (state_r == ST_SCAN) && (idx_r < n_r);
  assign rd_addr = AW'(idx_r);

  always_ff @(posedge clk) begin
    if (in_acc && wr_ok) begin
      mem[wr_addr] <= in_value;
    end
    if (issue) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Scan ends once every address is issued and the last read is consumed.
  assign scan_done = (state_r == ST_SCAN) && !issue && !rd_vld_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (query_acc) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
    end
  end

  // Address counter and scan length.
  always_ff @(posedge clk) begin
    if (query_acc) begin
      idx_r <= '0;
      n_r   <= n_nxt;
    end else if (issue) begin
      idx_r <= idx_r + LEN_W'(1);
    end
  end

  // Shared include/exclude unit.
  assign dp_ctl.clear = query_acc;
  assign dp_ctl.step  = rd_vld_r;

  nms_dp_unit u_dp (
    .clk  (clk),
    .ctl  (dp_ctl),
    .elem (mem_q_r),
    .best (best)
  );

  always_ff @(posedge clk) begin
    if (scan_done) begin
      sum_r <= best;
    end
  end

  // Running total: both operands are below the modulus, so one subtract suffices.
  assign tot_sum = {1'b0, total_r} + (TOTAL_W+1)'(sum_r);
  assign tot_nxt = (tot_sum >= TOTAL_MOD) ? TOTAL_W'(tot_sum - TOTAL_MOD)
                                          : tot_sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if ((state_r == ST_DONE) && out_free) begin
      total_r <= tot_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_sum_r   <= sum_r;
      out_total_r <= tot_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_query_max_sum = out_sum_r;
  assign out_running_total = out_total_r;

`ifndef SYNTH
  // An accepted query always starts a scan.
  a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> (state_r == ST_SCAN))
    else $error("query item did not start a scan");

  // Read data is only in flight during a scan.
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN))
    else $error("memory read outside a scan");

  // The address counter never passes the scan length.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= n_r))
    else $error("scan index beyond length");

  // The running total stays reduced.
  a_total_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, total_r} < TOTAL_MOD))
    else $error("running total not reduced");

  // A result appears only when a finished query hands it over.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result without a finished query");
`endif

endmodule

// ===== rtl/core/nms_dp_unit.sv =====
// Include/exclude scan unit: one element per step, shared over the whole scan.
// Depends on nms_pkg for widths and the dp_ctl_t control struct.
module nms_dp_unit
  import nms_pkg::*;
(
  input  logic                      clk,
  input  dp_ctl_t                   ctl,
  input  logic signed [VALUE_W-1:0] elem,
  output logic [QSUM_W-1:0]         best
);

  logic [SUM_W-1:0] incl_r;
  logic [SUM_W-1:0] excl_r;
  logic [SUM_W-1:0] incl_nxt;
  logic [SUM_W-1:0] excl_nxt;
  logic [SUM_W-1:0] gain;
  logic [SUM_W-1:0] larger;

  // Negative elements contribute nothing.
  assign gain = elem[VALUE_W-1] ? '0 : SUM_W'(unsigned'(elem[VALUE_W-2:0]));

  assign larger = (incl_r > excl_r) ? incl_r : excl_r;

  // One step of the recurrence, or a fresh start for a new query.
  always_comb begin
    incl_nxt = incl_r;
    excl_nxt = excl_r;
    if (ctl.clear) begin
      incl_nxt = '0;
      excl_nxt = '0;
    end else if (ctl.step) begin
      incl_nxt = excl_r + gain;
      excl_nxt = larger;
    end
  end

  always_ff @(posedge clk) begin
    incl_r <= incl_nxt;
    excl_r <= excl_nxt;
  end

  // Final answer saturates to the width of the result field.
  assign best = (larger > SUM_W'({QSUM_W{1'b1}})) ? {QSUM_W{1'b1}} : larger[QSUM_W-1:0];

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for nonadjacent_max_sum_updates: drives load and query items,
// predicts each query result in place and compares every result item field by field.
// Depends on nms_pkg and the RTL of the block only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nms_pkg::*;

  localparam int unsigned MAX_ELEMS = 1024;
  // Elements loaded up front; every scan stays within this prefix.
  localparam int FILL_LEN = 256;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 18'h1FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 18'h20000;
  localparam longint QSUM_SAT = (longint'(1) << QSUM_W) - 1;

  typedef struct {
    logic [QSUM_W-1:0]  qsum;
    logic [TOTAL_W-1:0] total;
  } query_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd = CMD_LOAD;
  logic [POS_W-1:0]    in_position = '0;
  logic [VALUE_W-1:0]  in_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [QSUM_W-1:0]   out_query_max_sum;
  logic [TOTAL_W-1:0]  out_running_total;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = ADDR_ARRAY_LENGTH;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // Predictor state: element store, array length and running total.
  logic signed [VALUE_W-1:0] element_mem [MAX_ELEMS];
  logic [LEN_W-1:0]          array_len_model;
  longint                    running_total_model;
  query_result_t             pending_results[$];

  int  fail_count = 0;
  int  items_sent = 0;
  int  queries_sent = 0;
  int  results_checked = 0;
  bit  in_gaps_on = 1'b1;
  bit  stall_on = 1'b1;
  int  stall_left = 0;

  nonadjacent_max_sum_updates #(.MAX_LEN(MAX_ELEMS)) dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3)) : int'($urandom_range(10, 60));
  endfunction

  // Element values: mostly within the documented range, some raw 18-bit patterns.
  function automatic logic [VALUE_W-1:0] rand_value();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 200000)) - 100000;
      4, 5:       v = int'($urandom);
      6:          v = int'(signed'(VALUE_MAX));
      7:          v = int'(signed'(VALUE_MIN));
      8:          v = int'($urandom_range(0, 20)) - 10;
      default:    v = $urandom_range(0, 1) ? 100000 : -100000;
    endcase
    return VALUE_W'(v);
  endfunction

  task automatic note_mismatch(input string what, input longint expv, input longint actv);
    fail_count++;
    if (fail_count <= 10)
      $display("Mismatch on %s: expected %0d, got %0d at %0t", what, expv, actv, $realtime);
  endtask

  // Applies one accepted item to the predictor and queues the expected query result.
  task automatic apply_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] val);
    longint incl, excl, nxt, gain, best;
    int     n;
    element_mem[pos] = val;
    if (cmd == CMD_LOAD) return;
    n = (array_len_model > MAX_ELEMS) ? MAX_ELEMS : int'(array_len_model);
    incl = 0;
    excl = 0;
    for (int i = 0; i < n; i++) begin
      gain = (element_mem[i] > 0) ? longint'(element_mem[i]) : 0;
      nxt  = (incl > excl) ? incl : excl;
      incl = excl + gain;
      excl = nxt;
    end
    best = (incl > excl) ? incl : excl;
    if (best > QSUM_SAT) best = QSUM_SAT;
    running_total_model = (running_total_model + best) % longint'(TOTAL_MOD);
    pending_results.push_back('{qsum: QSUM_W'(best), total: TOTAL_W'(running_total_model)});
    queries_sent++;
  endtask

  // Sends one item, with an optional gap before it, and waits until it is taken.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] val);
    int gap;
    gap = (in_gaps_on && $urandom_range(0, 1)) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (in_stall);
    apply_item(cmd, pos, val);
    items_sent++;
  endtask

  // Stops sending and waits until every expected result has come out.
  task automatic drain_results(input int tail);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Writes array_length over the configuration port, then reads it back.
  task automatic write_array_length(input logic [LEN_W-1:0] len);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_ARRAY_LENGTH;
    cfg_pwdata  <= 32'(len);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    array_len_model = len;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(len))
      note_mismatch("array_length readback", longint'(len), longint'(cfg_prdata));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Result side stalls: random holds of mixed length while enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each taken result item is compared with the oldest expected one.
  always @(posedge clk) begin
    query_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, query_max_sum", -1, longint'(out_query_max_sum));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_query_max_sum !== want.qsum)
          note_mismatch("query_max_sum", longint'(want.qsum), longint'(out_query_max_sum));
        if (out_running_total !== want.total)
          note_mismatch("running_total", longint'(want.total), longint'(out_running_total));
      end
    end
  end

  // The reset length of one scans element 0, which the query itself writes.
  task automatic test_reset_length();
    send_item(CMD_QUERY, 10'd0, 18'd5);
    send_item(CMD_QUERY, 10'd0, VALUE_W'(-7));
    send_item(CMD_LOAD, 10'd0, 18'd12);
    send_item(CMD_QUERY, 10'd1, 18'd9);
    drain_results(16);
  endtask

  // Fills the front of the store with alternating extremes and scans all of it,
  // then shortens the length so the last query writes just past the scan.
  task automatic test_full_store();
    write_array_length(LEN_W'(FILL_LEN));
    for (int i = 0; i < FILL_LEN; i++)
      send_item(CMD_LOAD, POS_W'(i), (i % 2 == 0) ? VALUE_MAX : VALUE_MIN);
    send_item(CMD_QUERY, 10'd0, VALUE_MAX);
    send_item(CMD_QUERY, 10'd1, VALUE_MAX);
    drain_results(16);
    write_array_length(LEN_W'(FILL_LEN - 1));
    send_item(CMD_QUERY, POS_W'(FILL_LEN - 1), VALUE_W'(-5));
    drain_results(16);
  endtask

  // Short directed sequences: field extremes, negative elements, writes past the
  // length, a length of zero and a length of one.
  task automatic test_directed();
    write_array_length(11'd4);
    send_item(CMD_LOAD, 10'd0, VALUE_MAX);
    send_item(CMD_LOAD, 10'd1, VALUE_MIN);
    send_item(CMD_LOAD, 10'd2, 18'd0);
    send_item(CMD_LOAD, 10'd3, VALUE_W'(-1));
    send_item(CMD_QUERY, 10'd2, 18'd5);
    send_item(CMD_QUERY, 10'd0, VALUE_W'(-1));
    send_item(CMD_QUERY, 10'd1023, 18'd100000);
    send_item(CMD_LOAD, 10'd1, 18'd100000);
    send_item(CMD_QUERY, 10'd3, 18'd100000);
    send_item(CMD_LOAD, 10'd1023, VALUE_MIN);
    drain_results(16);
    write_array_length(11'd0);
    send_item(CMD_QUERY, 10'd0, 18'd7);
    drain_results(16);
    write_array_length(11'd1);
    send_item(CMD_QUERY, 10'd0, VALUE_W'(-100000));
    send_item(CMD_QUERY, 10'd0, 18'd100000);
    drain_results(16);
  endtask

  // Random phases: each sets a length, then mixes loads and queries with random content.
  task automatic test_random_phases();
    logic [LEN_W-1:0] len;
    int               eff;
    logic [POS_W-1:0] pos;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       len = LEN_W'($urandom_range(1, 16));
        1:       len = LEN_W'(FILL_LEN);
        2:       len = 11'd0;
        3:       len = LEN_W'($urandom_range(FILL_LEN / 2, FILL_LEN));
        default: len = ($urandom_range(0, 4) != 0) ? LEN_W'($urandom_range(1, 40))
                                                   : LEN_W'($urandom_range(41, FILL_LEN));
      endcase
      in_gaps_on = (p != 0) && ($urandom_range(0, 3) != 0);
      stall_on   = (p != 0) && ($urandom_range(0, 3) != 0);
      write_array_length(len);
      eff = (len > MAX_ELEMS) ? MAX_ELEMS : int'(len);
      for (int k = 0; k < 25; k++) begin
        if (eff > 0 && $urandom_range(0, 9) < 7)
          pos = POS_W'($urandom_range(0, eff - 1));
        else
          pos = POS_W'($urandom_range(0, MAX_ELEMS - 1));
        send_item($urandom_range(0, 1) ? CMD_QUERY : CMD_LOAD, pos, rand_value());
      end
      drain_results(16);
    end
  endtask

  initial begin
    array_len_model     = ARRAY_LENGTH_RST;
    running_total_model = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_length();
    test_full_store();
    test_directed();
    test_random_phases();
    drain_results(32);
    $display("Sent %0d items, %0d of them queries, over scan lengths from 0 to %0d.",
             items_sent, queries_sent, FILL_LEN);
    $display("Checked %0d result items; %0d mismatches in total.", results_checked, fail_count);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
